@@ rtl/assert_macros.svh @@
// Assertion helpers; each macro expands to one labelled concurrent assertion
// clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rpct_pkg.sv @@
package rpct_pkg;

  // Field widths
  localparam int INFOSET_W   = 32;
  localparam int ACTION_W    = 4;
  localparam int REGRET_W    = 32;
  localparam int KEY_W       = INFOSET_W + ACTION_W;
  localparam int COOLDOWN_W  = 32;
  localparam int MASK_W      = 16;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  // Sizing defaults and limits
  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_ACTIONS       = 16;

  // Register reset values
  localparam logic signed [REGRET_W-1:0]   THRESHOLD_RST = 32'shFFFF_0000;
  localparam logic        [COOLDOWN_W-1:0] INTERVAL_RST  = 32'd8;
  localparam logic signed [REGRET_W-1:0]   BEST_RST      = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRUNE_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REVISIT_INTERVAL = 1'b1;

  // Commands
  localparam logic CMD_EVALUATE = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  // One table entry as held in the entry RAM
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COOLDOWN_W-1:0] cooldown;
    logic                  pruned;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Search unit status towards the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } scan_st_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOK,
    ST_UPDATE,
    ST_FINISH,
    ST_RESCUE,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/regret_pruning_cooldown_table_top.sv @@
// Channel   Direction  Transfer when               Payload
// s_axis    in         tvalid_i & tready_o         tdata: infoset, action, regret; tuser: cmd;
//                                                  tlast: last of span
// m_axis    out        tvalid_o & tready_i         tdata: status, mask, rescued, pruned flag
// cfg       in         cfg_we_i                    cfg_idx_i selects, cfg_data_i value
//
// One item is at work at a time; each lookup walks the stored entries (at most
// TABLE_ENTRIES) key by key through the one read port of the entry RAM, and a
// hit ends the walk early. A span's last item adds a rescue search when every
// action was pruned. Reset is asynchronous and clears entry count and span
// state, not the RAM. A result waits in the output register; a second one
// stalls until the first is taken.
`include "assert_macros.svh"

module regret_pruning_cooldown_table_top #(
  parameter int TABLE_ENTRIES = rpct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] infoset_id, [35:32] action_index, [67:36] regret, [71:68] zero
  input  logic [rpct_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] command
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  // Results
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [0] status, [16:1] pruned_mask, [17] rescued, [18] pruned_flag, [23:19] zero
  output logic [rpct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [rpct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rpct_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = rpct_pkg::INFOSET_W;
  localparam int XW = rpct_pkg::ACTION_W;
  localparam int RW = rpct_pkg::REGRET_W;
  localparam int DW = rpct_pkg::COOLDOWN_W;
  localparam int MW = rpct_pkg::MASK_W;

  rpct_pkg::state_e state_q, state_d;

  // Item registers
  logic                 cmd_q, cmd_d;
  logic [IW-1:0]        infoset_q, infoset_d;
  logic [XW-1:0]        action_q, action_d;
  logic signed [RW-1:0] regret_q, regret_d;
  logic                 last_q, last_d;

  // Configuration
  logic signed [RW-1:0] thr_q, thr_d;
  logic [DW-1:0]        intv_q, intv_d;

  // Table and span state
  logic [CW-1:0]        count_q, count_d;
  logic signed [RW-1:0] lead_regret_q, lead_regret_d;
  logic [XW-1:0]        lead_act_q, lead_act_d;
  logic                 live_q, live_d;
  logic [MW-1:0]        mask_q, mask_d;
  logic                 err_q, err_d;

  // Entry being worked on
  logic [AW-1:0]        slot_q, slot_d;
  logic [DW-1:0]        cd_q, cd_d;
  logic                 new_q, new_d;

  // Pending result and output register
  logic                 res_status_q, res_status_d;
  logic [MW-1:0]        res_mask_q, res_mask_d;
  logic                 res_rescued_q, res_rescued_d;
  logic                 res_flag_q, res_flag_d;
  logic                 out_valid_q, out_valid_d;
  logic [rpct_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Search unit and RAM
  logic                      scan_start;
  logic [rpct_pkg::KEY_W-1:0] key_lookup;
  rpct_pkg::entry_t          ram_rdata;
  rpct_pkg::entry_t          ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_we;
  rpct_pkg::scan_st_t        scan_st;
  logic [AW-1:0]             scan_slot;
  rpct_pkg::entry_t          scan_entry;

  // Miscellaneous decode
  logic                 accept;
  logic                 act_oor;
  logic                 table_full;
  logic                 can_load;
  logic [DW-1:0]        upd_cd;
  logic                 upd_pr;
  logic [MW-1:0]        action_bit;
  logic [MW-1:0]        best_bit;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign act_oor    = {{(32-XW){1'b0}}, action_q} >= 32'(rpct_pkg::MAX_ACTIONS);
  assign table_full = count_q >= CW'(TABLE_ENTRIES);
  assign can_load   = !out_valid_q || m_axis_tready_i;
  assign action_bit = MW'(1) << action_q;
  assign best_bit   = MW'(1) << lead_act_q;
  assign key_lookup = (state_q == rpct_pkg::ST_RESCUE) ? {infoset_q, lead_act_q}
                                                       : {infoset_q, action_q};

  // Cooldown and prune decision for the current entry
  always_comb begin
    if (cd_q > DW'(1)) begin
      upd_cd = cd_q - DW'(1);
      upd_pr = 1'b1;
    end else if (regret_q <= thr_q) begin
      upd_cd = intv_q;
      upd_pr = 1'b1;
    end else begin
      upd_cd = '0;
      upd_pr = 1'b0;
    end
  end

  rpct_ram #(
    .WIDTH (rpct_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpct_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .key_i   (key_lookup),
    .count_i (count_q),
    .rdata_i (ram_rdata),
    .raddr_o (ram_raddr),
    .stat_o  (scan_st),
    .slot_o  (scan_slot),
    .entry_o (scan_entry)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpct_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rpct_pkg::ST_CHECK;
        end
      end
      rpct_pkg::ST_CHECK: begin
        if (cmd_q == rpct_pkg::CMD_QUERY) begin
          state_d = rpct_pkg::ST_LOOK;
        end else if (err_q || act_oor) begin
          state_d = rpct_pkg::ST_FINISH;
        end else begin
          state_d = rpct_pkg::ST_LOOK;
        end
      end
      rpct_pkg::ST_LOOK: begin
        if (scan_st.done) begin
          if (cmd_q == rpct_pkg::CMD_QUERY) begin
            state_d = rpct_pkg::ST_EMIT;
          end else if (scan_st.found || !table_full) begin
            state_d = rpct_pkg::ST_UPDATE;
          end else begin
            state_d = rpct_pkg::ST_FINISH;
          end
        end
      end
      rpct_pkg::ST_UPDATE: begin
        state_d = rpct_pkg::ST_FINISH;
      end
      rpct_pkg::ST_FINISH: begin
        if (!last_q) begin
          state_d = rpct_pkg::ST_IDLE;
        end else if (err_q || live_q) begin
          state_d = rpct_pkg::ST_EMIT;
        end else begin
          state_d = rpct_pkg::ST_RESCUE;
        end
      end
      rpct_pkg::ST_RESCUE: begin
        if (scan_st.done) begin
          state_d = rpct_pkg::ST_EMIT;
        end
      end
      rpct_pkg::ST_EMIT: begin
        if (can_load) begin
          state_d = rpct_pkg::ST_IDLE;
        end
      end
      default: state_d = rpct_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, search start, RAM write
  always_comb begin
    s_axis_tready_o = 1'b0;
    scan_start      = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = slot_q;
    ram_wdata       = '{key: key_lookup, cooldown: upd_cd, pruned: upd_pr};
    unique case (state_q)
      rpct_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      rpct_pkg::ST_CHECK: begin
        scan_start = (cmd_q == rpct_pkg::CMD_QUERY) || (!err_q && !act_oor);
      end
      rpct_pkg::ST_UPDATE: begin
        ram_we = 1'b1;
      end
      rpct_pkg::ST_FINISH: begin
        scan_start = last_q && !err_q && !live_q;
      end
      rpct_pkg::ST_RESCUE: begin
        ram_we    = scan_st.done && scan_st.found;
        ram_waddr = scan_slot;
        ram_wdata = '{key: key_lookup, cooldown: '0, pruned: 1'b0};
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    cmd_d         = cmd_q;
    infoset_d     = infoset_q;
    action_d      = action_q;
    regret_d      = regret_q;
    last_d        = last_q;
    count_d       = count_q;
    lead_regret_d = lead_regret_q;
    lead_act_d    = lead_act_q;
    live_d        = live_q;
    mask_d        = mask_q;
    err_d         = err_q;
    slot_d        = slot_q;
    cd_d          = cd_q;
    new_d         = new_q;
    res_status_d  = res_status_q;
    res_mask_d    = res_mask_q;
    res_rescued_d = res_rescued_q;
    res_flag_d    = res_flag_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_data_d    = out_data_q;
    unique case (state_q)
      rpct_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d     = s_axis_tuser_i;
          infoset_d = s_axis_tdata_i[IW-1:0];
          action_d  = s_axis_tdata_i[IW+XW-1:IW];
          regret_d  = s_axis_tdata_i[IW+XW+RW-1:IW+XW];
          last_d    = s_axis_tlast_i;
          // Action 0 opens a new span and drops any unfinished one
          if (s_axis_tuser_i == rpct_pkg::CMD_EVALUATE &&
              s_axis_tdata_i[IW+XW-1:IW] == '0) begin
            lead_regret_d = rpct_pkg::BEST_RST;
            lead_act_d    = '0;
            live_d        = 1'b0;
            mask_d        = '0;
            err_d         = 1'b0;
          end
        end
      end
      rpct_pkg::ST_CHECK: begin
        if (cmd_q == rpct_pkg::CMD_EVALUATE && !err_q && act_oor) begin
          err_d = 1'b1;
        end
      end
      rpct_pkg::ST_LOOK: begin
        if (scan_st.done) begin
          if (cmd_q == rpct_pkg::CMD_QUERY) begin
            res_status_d  = !scan_st.found;
            res_mask_d    = '0;
            res_rescued_d = 1'b0;
            res_flag_d    = scan_st.found && scan_entry.pruned;
          end else if (scan_st.found) begin
            slot_d = scan_slot;
            cd_d   = scan_entry.cooldown;
            new_d  = 1'b0;
          end else if (!table_full) begin
            slot_d = count_q[AW-1:0];
            cd_d   = '0;
            new_d  = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
      end
      rpct_pkg::ST_UPDATE: begin
        if (new_q) begin
          count_d = count_q + CW'(1);
        end
        // First action always wins; later ones only on a strictly higher regret
        if (action_q == '0 || regret_q > lead_regret_q) begin
          lead_regret_d = regret_q;
          lead_act_d    = action_q;
        end
        if (upd_pr) begin
          mask_d = mask_q | action_bit;
        end else begin
          live_d = 1'b1;
        end
      end
      rpct_pkg::ST_FINISH: begin
        res_rescued_d = 1'b0;
        res_flag_d    = 1'b0;
        res_status_d  = err_q;
        res_mask_d    = err_q ? '0 : mask_q;
      end
      rpct_pkg::ST_RESCUE: begin
        if (scan_st.done) begin
          if (scan_st.found) begin
            res_status_d  = 1'b0;
            res_mask_d    = mask_q & ~best_bit;
            res_rescued_d = 1'b1;
          end else begin
            res_status_d  = 1'b1;
            res_mask_d    = '0;
            res_rescued_d = 1'b0;
          end
        end
      end
      rpct_pkg::ST_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, res_flag_q, res_rescued_q, res_mask_q, res_status_q};
          // A finished span returns to its reset state
          if (cmd_q == rpct_pkg::CMD_EVALUATE) begin
            lead_regret_d = rpct_pkg::BEST_RST;
            lead_act_d    = '0;
            live_d        = 1'b0;
            mask_d        = '0;
            err_d         = 1'b0;
          end
        end
      end
      default: begin
        out_data_d = out_data_q;
      end
    endcase
  end

  // Configuration register writes
  always_comb begin
    thr_d  = thr_q;
    intv_d = intv_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpct_pkg::REG_PRUNE_THRESHOLD:  thr_d  = cfg_data_i;
        rpct_pkg::REG_REVISIT_INTERVAL: intv_d = cfg_data_i;
        default: thr_d = thr_q;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rpct_pkg::ST_IDLE;
      thr_q         <= rpct_pkg::THRESHOLD_RST;
      intv_q        <= rpct_pkg::INTERVAL_RST;
      count_q       <= '0;
      lead_regret_q <= rpct_pkg::BEST_RST;
      lead_act_q    <= '0;
      live_q        <= 1'b0;
      mask_q        <= '0;
      err_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      thr_q         <= thr_d;
      intv_q        <= intv_d;
      count_q       <= count_d;
      lead_regret_q <= lead_regret_d;
      lead_act_q    <= lead_act_d;
      live_q        <= live_d;
      mask_q        <= mask_d;
      err_q         <= err_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    infoset_q     <= infoset_d;
    action_q      <= action_d;
    regret_q      <= regret_d;
    last_q        <= last_d;
    slot_q        <= slot_d;
    cd_q          <= cd_d;
    new_q         <= new_d;
    res_status_q  <= res_status_d;
    res_mask_q    <= res_mask_d;
    res_rescued_q <= res_rescued_d;
    res_flag_q    <= res_flag_d;
    out_data_q    <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  `ASSERT_ALWAYS(a_count_bound, count_q <= CW'(TABLE_ENTRIES),
    "entry count beyond table size")
  `ASSERT_IMPLIES(a_we_state, ram_we,
    state_q == rpct_pkg::ST_UPDATE || state_q == rpct_pkg::ST_RESCUE,
    "entry RAM written outside update or rescue")
  `ASSERT_IMPLIES(a_scan_done_state, scan_st.done,
    state_q == rpct_pkg::ST_LOOK || state_q == rpct_pkg::ST_RESCUE,
    "search finished while no lookup outstanding")
  `ASSERT_NEXT(a_one_item, accept, !s_axis_tready_o,
    "second item taken while one is at work")

endmodule

@@ rtl/rpct_ram.sv @@
module rpct_ram #(
  parameter int WIDTH = rpct_pkg::ENTRY_W,
  parameter int DEPTH = rpct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rpct_scan.sv @@
module rpct_scan #(
  parameter int TABLE_ENTRIES = rpct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rpct_pkg::KEY_W-1:0]       key_i,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] count_i,
  input  rpct_pkg::entry_t                 rdata_i,
  output logic [$clog2(TABLE_ENTRIES)-1:0] raddr_o,
  output rpct_pkg::scan_st_t               stat_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] slot_o,
  output rpct_pkg::entry_t                 entry_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic          busy_q, busy_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic          done_q, done_d;
  logic          found_q, found_d;
  logic [AW-1:0] slot_q, slot_d;
  rpct_pkg::entry_t entry_q, entry_d;
  logic          issue;
  logic          hit;
  logic          miss_end;

  // Read of entry idx is issued in the cycle before its key compare
  assign issue    = busy_q && (idx_q < count_i);
  assign hit      = busy_q && cmp_vld_q && (rdata_i.key == key_i);
  assign miss_end = busy_q && !cmp_vld_q && !issue;
  assign raddr_o  = idx_q[AW-1:0];

  // Scan sequencing
  always_comb begin
    busy_d    = busy_q;
    cmp_vld_d = cmp_vld_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    done_d    = 1'b0;
    found_d   = found_q;
    slot_d    = slot_q;
    entry_d   = entry_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cmp_vld_d = 1'b0;
      idx_d     = '0;
    end else if (hit || miss_end) begin
      busy_d    = 1'b0;
      cmp_vld_d = 1'b0;
      done_d    = 1'b1;
      found_d   = hit;
      slot_d    = cmp_idx_q;
      entry_d   = rdata_i;
    end else if (busy_q) begin
      cmp_vld_d = issue;
      cmp_idx_d = idx_q[AW-1:0];
      if (issue) begin
        idx_d = idx_q + CW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    found_q   <= found_d;
    slot_q    <= slot_d;
    entry_q   <= entry_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.found = found_q;
  assign slot_o       = slot_q;
  assign entry_o      = entry_q;

endmodule

@@ tb/regret_pruning_cooldown_table_top_test.sv @@
`timescale 1ns / 100ps

module regret_pruning_cooldown_table_top_test;

  localparam int TABLE_SIZE    = rpct_pkg::TABLE_ENTRIES_DEF;
  localparam int RG_W          = rpct_pkg::REGRET_W;
  localparam int ACT_W         = rpct_pkg::ACTION_W;
  localparam int CD_W          = rpct_pkg::COOLDOWN_W;
  // worst item: full search plus rescue search, with margin
  localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 80;
  localparam int HOLD_CYCLES   = 4000;
  localparam int IDLE_PCT      = 28;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int HOT_SETS      = 8;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic                                 cmd;
    logic [rpct_pkg::INFOSET_W-1:0]       infoset;
    logic [rpct_pkg::ACTION_W-1:0]        action;
    logic signed [rpct_pkg::REGRET_W-1:0] regret;
    logic                                 last;
  } eval_item_t;

  // Result fields in tdata order, lowest bit last
  typedef struct packed {
    logic                        pruned_flag;
    logic                        rescued;
    logic [rpct_pkg::MASK_W-1:0] mask;
    logic                        status;
  } verdict_t;

  // Shadow of the entry table and span tracking; queues the expected verdicts
  class prune_table_mirror;
    logic [rpct_pkg::KEY_W-1:0]           keys [TABLE_SIZE];
    logic [rpct_pkg::COOLDOWN_W-1:0]      cooldown [TABLE_SIZE];
    bit                                   pruned [TABLE_SIZE];
    int unsigned                          fill;
    logic signed [rpct_pkg::REGRET_W-1:0] threshold;
    logic [rpct_pkg::COOLDOWN_W-1:0]      interval;
    logic signed [rpct_pkg::REGRET_W-1:0] lead_regret;
    logic [rpct_pkg::ACTION_W-1:0]        lead_act;
    bit                                   live;
    bit                                   err;
    logic [rpct_pkg::MASK_W-1:0]          mask;
    verdict_t                             due [$];
    int                                   mismatches;

    function new();
      threshold  = rpct_pkg::THRESHOLD_RST;
      interval   = rpct_pkg::INTERVAL_RST;
      fill       = 0;
      mismatches = 0;
      clear_span();
    endfunction

    function void clear_span();
      lead_regret = rpct_pkg::BEST_RST;
      lead_act    = '0;
      live        = 0;
      err         = 0;
      mask        = '0;
    endfunction

    function int find(logic [rpct_pkg::KEY_W-1:0] key);
      for (int i = 0; i < fill; i++)
        if (keys[i] == key) return i;
      return -1;
    endfunction

    function void absorb_item(eval_item_t it);
      logic [rpct_pkg::KEY_W-1:0] key;
      int                         slot;
      verdict_t                   v;
      key = {it.infoset, it.action};
      v   = '0;

      // query: no span or table change, last flag ignored
      if (it.cmd == rpct_pkg::CMD_QUERY) begin
        slot          = find(key);
        v.status      = (slot < 0);
        v.pruned_flag = (slot < 0) ? 1'b0 : pruned[slot];
        due.push_back(v);
        return;
      end

      // action 0 opens a fresh span, dropping any unfinished one
      if (it.action == '0) clear_span();

      // the 4-bit action field cannot reach MAX_ACTIONS
      if (!err) begin
        slot = find(key);
        if (slot < 0) begin
          if (fill >= TABLE_SIZE) begin
            err = 1;
          end else begin
            slot           = fill;
            keys[slot]     = key;
            cooldown[slot] = '0;
            pruned[slot]   = 0;
            fill++;
          end
        end
        if (!err) begin
          if (it.action == '0 || it.regret > lead_regret) begin
            lead_regret = it.regret;
            lead_act    = it.action;
          end
          if (cooldown[slot] > 1) begin
            cooldown[slot]--;
            pruned[slot] = 1;
          end else if (it.regret <= threshold) begin
            cooldown[slot] = interval;
            pruned[slot]   = 1;
          end else begin
            cooldown[slot] = '0;
            pruned[slot]   = 0;
          end
          if (pruned[slot]) mask[it.action] = 1'b1;
          else live = 1;
        end
      end

      if (!it.last) return;

      // everything pruned: bring back the best action
      if (!err && !live) begin
        slot = find({it.infoset, lead_act});
        if (slot < 0) begin
          err = 1;
        end else begin
          cooldown[slot] = '0;
          pruned[slot]   = 0;
          mask[lead_act] = 1'b0;
          v.rescued      = 1'b1;
        end
      end
      v.status = err;
      v.mask   = err ? '0 : mask;
      if (err) v.rescued = 1'b0;
      due.push_back(v);
      clear_span();
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void match_verdict(logic [rpct_pkg::OUT_TDATA_W-1:0] word);
      verdict_t want;
      verdict_t got;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result %h with nothing outstanding", $time, word);
        return;
      end
      got  = word[$bits(verdict_t)-1:0];
      want = due.pop_front();
      check_field("status", want.status, got.status);
      check_field("pruned_mask", want.mask, got.mask);
      check_field("rescued", want.rescued, got.rescued);
      check_field("pruned_flag", want.pruned_flag, got.pruned_flag);
      check_field("padding", 0, word[rpct_pkg::OUT_TDATA_W-1:$bits(verdict_t)]);
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [rpct_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                             s_axis_tuser_i;
  logic                             s_axis_tlast_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [rpct_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                             cfg_we_i;
  logic [rpct_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [rpct_pkg::CFG_W-1:0]       cfg_data_i;

  prune_table_mirror              mirror;
  int                             items_sent;
  int                             verdicts_seen;
  bit                             held_off;
  logic                           calm;
  logic [rpct_pkg::INFOSET_W-1:0] hot_set [HOT_SETS];
  int                             hot_len [HOT_SETS];

  // stretch with no idling on either side
  assign calm = (items_sent >= 700) && (items_sent < 950);

  regret_pruning_cooldown_table_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Transfers on both channels, sampled at the rising edge
  always @(posedge clk_i) begin : watch
    eval_item_t seen;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      seen.cmd     = s_axis_tuser_i;
      seen.infoset = s_axis_tdata_i[rpct_pkg::INFOSET_W-1:0];
      seen.action  = s_axis_tdata_i[rpct_pkg::INFOSET_W +: rpct_pkg::ACTION_W];
      seen.regret  = s_axis_tdata_i[rpct_pkg::KEY_W +: rpct_pkg::REGRET_W];
      seen.last    = s_axis_tlast_i;
      mirror.absorb_item(seen);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      mirror.match_verdict(m_axis_tdata_o);
      verdicts_seen++;
    end
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin : sink
    m_axis_tready_i = 1'b0;
    held_off        = 0;
    forever begin
      @(negedge clk_i);
      if (!held_off && verdicts_seen >= 60) begin
        held_off        = 1;
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready_i = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    #(64'd80_000_000);
    $display("regret_pruning_cooldown_table_top_test NOT OK");
    $finish;
  end

  task automatic send_item(input logic cmd,
                           input logic [rpct_pkg::INFOSET_W-1:0] infoset,
                           input logic [rpct_pkg::ACTION_W-1:0] action,
                           input logic [rpct_pkg::REGRET_W-1:0] regret,
                           input logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {{(rpct_pkg::IN_TDATA_W - rpct_pkg::KEY_W - rpct_pkg::REGRET_W){1'b0}},
                       regret, action, infoset};
    s_axis_tuser_i  = cmd;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // Drain all results, then give the block time to finish silent items
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (mirror.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rpct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpct_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == rpct_pkg::REG_PRUNE_THRESHOLD) mirror.threshold = val;
    else mirror.interval = val;
  endtask

  // sink set: a regret at or below the current threshold
  function automatic logic [rpct_pkg::REGRET_W-1:0] draw_regret(bit sink);
    longint lo;
    longint room;
    logic signed [rpct_pkg::REGRET_W-1:0] thr;
    thr  = mirror.threshold;
    lo   = longint'(rpct_pkg::BEST_RST);
    room = longint'(thr) - lo + 1;
    if (sink) begin
      case ($urandom_range(0, 2))
        0:       return thr;
        1:       return rpct_pkg::BEST_RST;
        default: return RG_W'(lo + (longint'($urandom) % room));
      endcase
    end
    case ($urandom_range(0, 5))
      0:       return thr;
      1:       return thr + 1;
      2:       return thr - 1;
      3:       return 32'h7FFF_FFFF;
      4:       return rpct_pkg::BEST_RST;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic signed [rpct_pkg::REGRET_W-1:0] thr_set [PHASES];
    logic [rpct_pkg::COOLDOWN_W-1:0]      gap_set [PHASES];
    logic [rpct_pkg::INFOSET_W-1:0]       inf;
    int                                   phase_end;
    int                                   pick;
    int                                   k;
    int                                   len;
    int                                   stop;
    bit                                   sink_all;
    bit                                   cut;

    mirror          = new();
    items_sent      = 0;
    verdicts_seen   = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;

    thr_set = '{rpct_pkg::THRESHOLD_RST, rpct_pkg::BEST_RST, 32'shFFFF_FFFF,
                32'sh4000_0000, {1'b1, 31'($urandom)}, 32'shFFFC_0000};
    gap_set = '{rpct_pkg::INTERVAL_RST, 32'd1, 32'hFFFF_FFFF, 32'd0,
                CD_W'($urandom_range(2, 20)), 32'd3};
    for (int i = 0; i < HOT_SETS; i++) begin
      hot_set[i] = {8'($urandom_range(16, 255)), 24'($urandom)};
      hot_len[i] = (i == 0) ? rpct_pkg::MAX_ACTIONS : $urandom_range(1, rpct_pkg::MAX_ACTIONS);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: absent query carrying tlast
    send_item(rpct_pkg::CMD_QUERY, 32'd0, 4'd0, 32'd0, 1'b1);
    // Extreme key, extreme regrets, threshold tie, gap before the top action
    send_item(rpct_pkg::CMD_EVALUATE, 32'hFFFF_FFFF, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'hFFFF_FFFF, 4'd1, rpct_pkg::THRESHOLD_RST, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'hFFFF_FFFF, 4'd2, rpct_pkg::THRESHOLD_RST + 1, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'hFFFF_FFFF, 4'd3, rpct_pkg::BEST_RST, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'hFFFF_FFFF, 4'd15, 32'd0, 1'b1);
    send_item(rpct_pkg::CMD_QUERY, 32'hFFFF_FFFF, 4'd1, 32'hFFFF_FFFF, 1'b0);
    send_item(rpct_pkg::CMD_QUERY, 32'hFFFF_FFFF, 4'd2, 32'd0, 1'b0);
    // All pruned with a tie on the best regret: first best is rescued
    send_item(rpct_pkg::CMD_EVALUATE, 32'd1, 4'd0, 32'shFFFD_0000, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd1, 4'd1, 32'shFFFE_0000, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd1, 4'd2, 32'shFFFE_0000, 1'b1);
    // Cooldown keeps action 0 pruned; the rescued action comes back live
    send_item(rpct_pkg::CMD_EVALUATE, 32'd1, 4'd0, 32'h0010_0000, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd1, 4'd1, 32'h0010_0000, 1'b1);
    // Unfinished span dropped by the next span start
    send_item(rpct_pkg::CMD_EVALUATE, 32'd2, 4'd0, 32'd5, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd2, 4'd1, 32'd6, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd3, 4'd0, 32'd7, 1'b0);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd3, 4'd1, rpct_pkg::BEST_RST, 1'b1);
    // Span without action 0: rescue target absent gives an error
    send_item(rpct_pkg::CMD_EVALUATE, 32'd4, 4'd5, rpct_pkg::BEST_RST, 1'b1);
    // Single-action spans, live and rescued
    send_item(rpct_pkg::CMD_EVALUATE, 32'd5, 4'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(rpct_pkg::CMD_EVALUATE, 32'd6, 4'd0, rpct_pkg::BEST_RST, 1'b1);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(rpct_pkg::REG_PRUNE_THRESHOLD, thr_set[p]);
      write_reg(rpct_pkg::REG_REVISIT_INTERVAL, gap_set[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          inf = $urandom_range(0, 1) ? hot_set[$urandom_range(0, HOT_SETS - 1)] : $urandom;
          send_item(rpct_pkg::CMD_QUERY, inf, 4'($urandom), $urandom, 1'($urandom));
        end else if (pick < 18) begin
          // stray evaluate, out of order and with a random last flag
          send_item(rpct_pkg::CMD_EVALUATE, hot_set[$urandom_range(0, HOT_SETS - 1)],
                    4'($urandom), draw_regret(1'($urandom)), 1'($urandom));
        end else begin
          // fresh keys from the third phase on fill the table up
          if (p >= 2 && $urandom_range(0, 2) == 0) begin
            inf = $urandom;
            len = $urandom_range(1, rpct_pkg::MAX_ACTIONS);
          end else begin
            k   = $urandom_range(0, HOT_SETS - 1);
            inf = hot_set[k];
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rpct_pkg::MAX_ACTIONS)
                                              : hot_len[k];
          end
          cut      = ($urandom_range(0, 19) == 0);
          stop     = cut ? $urandom_range(1, len) : len;
          sink_all = ($urandom_range(0, 99) < 30);
          for (int a = 0; a < stop; a++)
            send_item(rpct_pkg::CMD_EVALUATE, inf, ACT_W'(a),
                      draw_regret(sink_all || $urandom_range(0, 99) < 40),
                      !cut && (a == len - 1));
        end
      end
    end

    settle();
    if (mirror.mismatches == 0 && mirror.due.size() == 0) begin
      $display("regret_pruning_cooldown_table_top_test OK");
    end else begin
      $display("regret_pruning_cooldown_table_top_test NOT OK");
    end
    $finish;
  end

endmodule
